FILE: design/pfrm_pkg.sv
package pfrm_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int RATE_W     = 32;
    localparam int CAL_W      = 16;
    localparam int DEN_W      = TIME_W + CAL_W;
    localparam int CNT_W      = 5;
    localparam int PRE_SHIFT  = 8;   // integer part of the quotient is below 2^8
    localparam int FRAC_BITS  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_FACTOR   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_TIMEOUT = 8'd2;

    localparam logic [CFG_DATA_W-1:0] CAL_FACTOR_RESET   = 16'd1920;
    localparam logic [CFG_DATA_W-1:0] MIN_WINDOW_RESET   = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] FLOW_TIMEOUT_RESET = 16'd1000;

    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CNT_W-1:0] MUL_LAST = 5'd15;
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_CHECK,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic start;
        logic zero_rate;
    } div_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } div_stat_t;

endpackage

FILE: design/pfrm_channels.sv
interface pfrm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [pfrm_pkg::TIME_W-1:0] time_ms;

    modport source (output valid, output req_type, output time_ms, input ready);
    modport sink   (input valid, input req_type, input time_ms, output ready);
endinterface

interface pfrm_out_if;
    logic                        valid;
    logic                        ready;
    logic [pfrm_pkg::RATE_W-1:0] flow_rate;
    logic                        flowing;

    modport source (output valid, output flow_rate, output flowing, input ready);
    modport sink   (input valid, input flow_rate, input flowing, output ready);
endinterface

FILE: design/pfrm_window.sv
module pfrm_window #(
    parameter int COUNT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pulse_en,
    input  logic [pfrm_pkg::TIME_W-1:0]     time_ms,
    input  logic [pfrm_pkg::CFG_DATA_W-1:0] min_window,
    input  logic [pfrm_pkg::CFG_DATA_W-1:0] flow_timeout,
    output logic                            flowing,
    output logic [COUNT_BITS-1:0]           latched_pulses,
    output logic [pfrm_pkg::TIME_W-1:0]     latched_duration
);

    logic [pfrm_pkg::TIME_W-1:0] window_start_reg;
    logic [pfrm_pkg::TIME_W-1:0] last_pulse_reg;
    logic [pfrm_pkg::TIME_W-1:0] lat_dur_reg;
    logic [COUNT_BITS-1:0]       count_reg;
    logic [COUNT_BITS-1:0]       lat_pulses_reg;
    logic                        seen_reg;

    logic [pfrm_pkg::TIME_W-1:0] elapsed;
    logic [pfrm_pkg::TIME_W-1:0] since_last;
    logic [COUNT_BITS-1:0]       count_inc;
    logic                        close_win;

    assign elapsed    = time_ms - window_start_reg;
    assign since_last = time_ms - last_pulse_reg;
    // counter saturates at all ones
    assign count_inc  = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign close_win  = elapsed > pfrm_pkg::TIME_W'(min_window);

    assign flowing = seen_reg && (since_last < pfrm_pkg::TIME_W'(flow_timeout));
    assign latched_pulses   = lat_pulses_reg;
    assign latched_duration = lat_dur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= '0;
            last_pulse_reg   <= '0;
            lat_dur_reg      <= '0;
            count_reg        <= '0;
            lat_pulses_reg   <= '0;
            seen_reg         <= 1'b0;
        end
        else if (pulse_en)
        begin
            last_pulse_reg <= time_ms;
            seen_reg       <= 1'b1;
            if (close_win)
            begin
                lat_dur_reg      <= elapsed;
                lat_pulses_reg   <= count_inc;
                window_start_reg <= time_ms;
                count_reg        <= '0;
            end
            else
            begin
                count_reg <= count_inc;
            end
        end
    end

endmodule

FILE: design/pfrm_divider.sv
module pfrm_divider #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfrm_pkg::div_cmd_t             cmd,
    input  logic                           out_free,
    input  logic [COUNT_BITS-1:0]          pulses,
    input  logic [pfrm_pkg::TIME_W-1:0]    duration,
    input  logic [pfrm_pkg::CAL_W-1:0]     cal,
    output pfrm_pkg::div_stat_t            stat,
    output logic [pfrm_pkg::RATE_W-1:0]    rate
);

    localparam int NUM_W = COUNT_BITS + 10;   // pulses * 1000

    pfrm_pkg::div_state_t state_reg, state_next;

    logic [pfrm_pkg::CNT_W-1:0]  cnt_reg;
    logic [pfrm_pkg::TIME_W-1:0] mcand_reg;
    logic [pfrm_pkg::CAL_W-1:0]  mplier_reg;
    logic [pfrm_pkg::DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [pfrm_pkg::DEN_W-1:0]  rem_reg;
    logic [pfrm_pkg::RATE_W-1:0] feed_reg;
    logic [pfrm_pkg::RATE_W-1:0] quot_reg;

    logic [NUM_W-1:0]            num_w;
    logic [pfrm_pkg::DEN_W-1:0]  num_hi;
    logic [pfrm_pkg::DEN_W:0]    trial;
    logic [pfrm_pkg::DEN_W:0]    diff;
    logic                        take;
    logic                        sat;

    // x*1000 = x*1024 - x*32 + x*8
    assign num_w = (NUM_W'(pulses) << 10) - (NUM_W'(pulses) << 5) + (NUM_W'(pulses) << 3);
    assign num_hi = pfrm_pkg::DEN_W'(num_reg[NUM_W-1:pfrm_pkg::PRE_SHIFT]);
    assign trial  = {rem_reg, feed_reg[pfrm_pkg::RATE_W-1]};
    assign diff   = trial - {1'b0, den_reg};
    assign take   = trial >= {1'b0, den_reg};
    // zero divisor, or integer part of the quotient past 8 bits
    assign sat    = (den_reg == '0) || (num_hi >= den_reg);

    assign rate = quot_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfrm_pkg::DIV_IDLE:
            begin
                if (cmd.start)
                    state_next = cmd.zero_rate ? pfrm_pkg::DIV_DONE : pfrm_pkg::DIV_MUL;
            end
            pfrm_pkg::DIV_MUL:
            begin
                if (cnt_reg == pfrm_pkg::MUL_LAST)
                    state_next = pfrm_pkg::DIV_CHECK;
            end
            pfrm_pkg::DIV_CHECK:
            begin
                state_next = sat ? pfrm_pkg::DIV_DONE : pfrm_pkg::DIV_RUN;
            end
            pfrm_pkg::DIV_RUN:
            begin
                if (cnt_reg == pfrm_pkg::DIV_LAST)
                    state_next = pfrm_pkg::DIV_DONE;
            end
            pfrm_pkg::DIV_DONE:
            begin
                if (out_free)
                    state_next = pfrm_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = pfrm_pkg::DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stat.idle = (state_reg == pfrm_pkg::DIV_IDLE);
        stat.done = (state_reg == pfrm_pkg::DIV_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfrm_pkg::DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                pfrm_pkg::DIV_MUL,
                pfrm_pkg::DIV_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    // datapath: shift-add multiply MSB first, then restoring divide one bit a cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pfrm_pkg::DIV_IDLE:
            begin
                if (cmd.start)
                begin
                    mcand_reg  <= duration;
                    mplier_reg <= cal;
                    den_reg    <= '0;
                    num_reg    <= num_w;
                    quot_reg   <= '0;
                end
            end
            pfrm_pkg::DIV_MUL:
            begin
                den_reg <= (den_reg << 1)
                         + (mplier_reg[pfrm_pkg::CAL_W-1] ? pfrm_pkg::DEN_W'(mcand_reg) : '0);
                mplier_reg <= mplier_reg << 1;
            end
            pfrm_pkg::DIV_CHECK:
            begin
                if (sat)
                begin
                    quot_reg <= '1;
                end
                else
                begin
                    rem_reg  <= num_hi;
                    feed_reg <= {num_reg[pfrm_pkg::PRE_SHIFT-1:0],
                                 {pfrm_pkg::FRAC_BITS{1'b0}}};
                end
            end
            pfrm_pkg::DIV_RUN:
            begin
                rem_reg  <= take ? diff[pfrm_pkg::DEN_W-1:0] : trial[pfrm_pkg::DEN_W-1:0];
                feed_reg <= feed_reg << 1;
                quot_reg <= {quot_reg[pfrm_pkg::RATE_W-2:0], take};
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: design/pulse_flow_rate_meter_unit.sv
// Pulse flow rate meter. Each input transfer is either a sensor pulse (req_type 0) or a
// rate query (req_type 1), stamped with a wrapping millisecond time. Pulses are counted
// into a window that closes on the first pulse more than min_window ms after its start;
// the closed window's count and length are held for queries. A query returns
// count * 1000 / length / (cal_factor / 256) in l/min as unsigned Q16.16, saturated,
// plus a flowing flag; the rate reads zero when no pulse came within flow_timeout ms or
// no window has closed yet. Pulses can arrive every cycle while the divider is idle.
// A query that computes a rate holds the input: a shift-add multiply (one
// cal_factor bit per cycle) builds the divisor, a check for saturation follows, a
// restoring divider retires one quotient bit per cycle, and the result is handed to
// the output register once that register is free. A saturated rate skips the divider
// and a zero rate skips both. The result sits in an output register, so the next
// transfer can be taken while it waits. Configuration registers (index 0 cal_factor,
// 1 min_window, 2 flow_timeout, others ignored) must be written only while no query
// is in flight; the block itself does not enforce this.
module pulse_flow_rate_meter_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pfrm_in_if.sink                          in_ch,
    pfrm_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [pfrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfrm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration
    logic [pfrm_pkg::CFG_DATA_W-1:0] cal_factor_reg;
    logic [pfrm_pkg::CFG_DATA_W-1:0] min_window_reg;
    logic [pfrm_pkg::CFG_DATA_W-1:0] flow_timeout_reg;

    // result slot
    logic                        out_valid_reg;
    logic [pfrm_pkg::RATE_W-1:0] out_rate_reg;
    logic                        out_flowing_reg;
    logic                        flowing_reg;   // flag of the query in flight

    logic                        accept;
    logic                        pulse_en;
    logic                        flowing;
    logic                        out_free;
    logic [COUNT_BITS-1:0]       latched_pulses;
    logic [pfrm_pkg::TIME_W-1:0] latched_duration;
    logic [pfrm_pkg::RATE_W-1:0] rate;
    pfrm_pkg::div_cmd_t          div_cmd;
    pfrm_pkg::div_stat_t         div_stat;

    // a new transfer only while the divider is free
    assign in_ch.ready = div_stat.idle;
    assign accept      = in_ch.valid && in_ch.ready;
    assign pulse_en    = accept && (in_ch.req_type == pfrm_pkg::REQ_PULSE);

    assign div_cmd.start     = accept && (in_ch.req_type == pfrm_pkg::REQ_QUERY);
    assign div_cmd.zero_rate = !flowing || (latched_duration == '0);

    // slot is free now or frees at this edge
    assign out_free = !out_valid_reg || out_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.flow_rate = out_rate_reg;
    assign out_ch.flowing   = out_flowing_reg;

    pfrm_window #(
        .COUNT_BITS (COUNT_BITS)
    ) u_window (
        .clk              (clk),
        .rst_n            (rst_n),
        .pulse_en         (pulse_en),
        .time_ms          (in_ch.time_ms),
        .min_window       (min_window_reg),
        .flow_timeout     (flow_timeout_reg),
        .flowing          (flowing),
        .latched_pulses   (latched_pulses),
        .latched_duration (latched_duration)
    );

    pfrm_divider #(
        .COUNT_BITS (COUNT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .out_free (out_free),
        .pulses   (latched_pulses),
        .duration (latched_duration),
        .cal      (cal_factor_reg),
        .stat     (div_stat),
        .rate     (rate)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_factor_reg   <= pfrm_pkg::CAL_FACTOR_RESET;
            min_window_reg   <= pfrm_pkg::MIN_WINDOW_RESET;
            flow_timeout_reg <= pfrm_pkg::FLOW_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfrm_pkg::CFG_CAL_FACTOR:   cal_factor_reg   <= cfg_data;
                pfrm_pkg::CFG_MIN_WINDOW:   min_window_reg   <= cfg_data;
                pfrm_pkg::CFG_FLOW_TIMEOUT: flow_timeout_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (div_stat.done)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (div_cmd.start)
            flowing_reg <= flowing;
        if (div_stat.done)
        begin
            out_rate_reg    <= rate;
            out_flowing_reg <= flowing_reg;
        end
    end

endmodule
